[sv/mstk_pkg.sv]
// ----------------------------------------------------------------------------
// mstk_pkg
// Shared constants for the minimum spanning tree block.
// ----------------------------------------------------------------------------
package mstk_pkg;
  localparam int unsigned NodeBits   = 4;
  localparam int unsigned CountBits  = 5;
  localparam int unsigned SumBits    = 20;
  localparam int unsigned TreeBits   = 4;
  localparam int unsigned ReqBits    = 5;
  // node numbers and weights are fixed by the stream layout
  localparam int unsigned MaxNodes   = 16;
  localparam int unsigned WeightBits = 16;
endpackage

[sv/min_spanning_tree_kruskal.sv]
// ----------------------------------------------------------------------------
// min_spanning_tree_kruskal
// Kruskal minimum spanning tree with a path-compressed union-find table.
// ----------------------------------------------------------------------------
// Edges load one beat per cycle into an edge RAM. The beat with tlast set
// starts the solve: a stable insertion sort over an index RAM (O(E^2)
// compares or moves for E stored edges), then a union-find walk that
// finds and compresses roots one parent step per cycle. The loader is not
// ready while a solve runs or results wait; edge records, then a summary
// with m_tuser set, leave through a registered output stage.
module min_spanning_tree_kruskal
  import mstk_pkg::*;
#(
  parameter int unsigned MAX_EDGES   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // from_node[3:0], to_node[7:4], edge_weight[23:8]
  input  logic        s_tlast,   // last_edge
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // tree_from, tree_to, tree_weight, total_weight,
                                 // tree_edges, overflow; zero fill
  output logic        m_tuser,   // is_summary
  output logic        m_tlast    // last_result
);
  localparam int unsigned NB = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned EB = $clog2(MAX_EDGES);
  localparam int unsigned EW = 2 * NodeBits + WeightBits;

  typedef enum logic [4:0] {
    S_LOAD, S_SI, S_SJ, S_SRD, S_SCMP, S_SMOV, S_SPUT, S_CLR,
    S_WRD, S_WWAIT, S_WGET, S_FA, S_CA, S_FB, S_CB, S_JOIN, S_OUT, S_SUM
  } state_t;

  state_t state;
  logic [4:0]    node_count;
  logic [EB:0]   loaded;
  logic          dropped;
  logic [SumBits-1:0] wsum;
  logic [TreeBits-1:0] acc;
  logic [EB:0]   i, j;
  logic [WeightBits-1:0] cur_w;
  logic [EB-1:0] prev_idx;
  logic [NB-1:0] parent [MaxNodes];
  logic [NB-1:0] clr;
  logic [NodeBits-1:0] ef, et;
  logic [WeightBits-1:0] ew;
  logic [NB-1:0] r, c, ra;

  // edge RAM
  logic          e_we;
  logic [EB-1:0] e_wa, e_ra;
  logic [EW-1:0] e_wd, e_rd;
  // order RAM
  logic          o_we;
  logic [EB-1:0] o_wa, o_ra;
  logic [EB-1:0] o_wd, o_rd;

  mstk_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  mstk_ram #(.WIDTH(EB), .DEPTH(MAX_EDGES)) u_order (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));

  logic [NodeBits-1:0] in_f, in_t;
  logic in_ok;
  assign in_f = s_tdata[3:0];
  assign in_t = s_tdata[7:4];
  assign in_ok = ({1'b0, in_f} < node_count) && ({1'b0, in_t} < node_count);
  assign s_tready = (state == S_LOAD) && !m_tvalid;

  logic [NB-1:0] nt;
  assign nt = NB'(et);

  always_comb begin
    e_we = 1'b0;
    e_wa = loaded[EB-1:0];
    e_wd = {s_tdata[8 +: WeightBits], in_t, in_f};
    e_ra = i[EB-1:0];
    o_we = 1'b0;
    o_wa = j[EB-1:0];
    o_wd = prev_idx;
    o_ra = EB'(j - 1'b1);
    unique case (state)
      S_LOAD: e_we = s_tvalid && s_tready && in_ok && (loaded < (EB+1)'(MAX_EDGES));
      S_SRD:  e_ra = o_rd;
      S_SMOV: begin
        o_we = 1'b1;
        // next compare needs the entry below the one being moved
        o_ra = EB'(j - 2'd2);
      end
      S_SPUT: begin
        o_we = 1'b1;
        o_wd = i[EB-1:0];
      end
      S_WRD, S_WWAIT: o_ra = i[EB-1:0];
      S_WGET: e_ra = o_rd;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      node_count <= 5'd16;
      loaded     <= '0;
      dropped    <= 1'b0;
      wsum       <= '0;
      acc        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata < 5'd2) node_count <= 5'd2;
        else if (32'(cfg_wdata) > MaxNodes) node_count <= 5'(MaxNodes);
        else node_count <= cfg_wdata;
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_LOAD: if (s_tvalid && s_tready) begin
          if (in_ok) begin
            if (loaded < (EB+1)'(MAX_EDGES)) loaded <= loaded + 1'b1;
            else dropped <= 1'b1;
          end
          if (s_tlast) begin
            i <= '0;
            state <= S_SI;
          end
        end
        S_SI: begin
          if (i == loaded) begin
            clr <= '0;
            state <= S_CLR;
          end else begin
            j <= i;
            state <= S_SJ;
          end
        end
        S_SJ: begin  // e_ra = i : current weight
          state <= S_SRD;
        end
        S_SRD: begin  // e_rd current; o_rd = order[j-1]
          if (j == i) cur_w <= e_rd[EW-1 -: WeightBits];
          if (j == '0) state <= S_SPUT;
          else begin
            prev_idx <= o_rd;
            state <= S_SCMP;
          end
        end
        S_SCMP: begin  // e_rd = edge[order[j-1]]
          if (e_rd[EW-1 -: WeightBits] > cur_w) state <= S_SMOV;
          else state <= S_SPUT;
        end
        S_SMOV: begin
          j <= j - 1'b1;
          state <= S_SRD;
        end
        S_SPUT: begin
          i <= i + 1'b1;
          state <= S_SI;
        end
        S_CLR: begin
          parent[clr] <= clr;
          clr <= clr + 1'b1;
          if (32'(clr) == MaxNodes - 1) begin
            wsum <= '0;
            acc <= '0;
            i <= '0;
            state <= S_WRD;
          end
        end
        S_WRD: begin
          if (i == loaded || ({1'b0, acc} + 5'd1) >= node_count) state <= S_SUM;
          else state <= S_WWAIT;
        end
        S_WWAIT: state <= S_WGET;
        S_WGET: state <= S_FA;  // e_rd valid next cycle
        S_FA: begin
          ef <= e_rd[NodeBits-1:0];
          et <= e_rd[2*NodeBits-1:NodeBits];
          ew <= e_rd[EW-1 -: WeightBits];
          r <= NB'(e_rd[NodeBits-1:0]);
          c <= NB'(e_rd[NodeBits-1:0]);
          state <= S_CA;
        end
        S_CA: begin  // find root, then compress
          if (parent[r] != r) r <= parent[r];
          else if (c != r) begin
            parent[c] <= r;
            c <= parent[c];
          end else begin
            ra <= r;
            r <= nt;
            c <= nt;
            state <= S_FB;
          end
        end
        S_FB: state <= S_CB;
        S_CB: begin
          if (parent[r] != r) r <= parent[r];
          else if (c != r) begin
            parent[c] <= r;
            c <= parent[c];
          end else state <= S_JOIN;
        end
        S_JOIN: begin
          if (ra != r) begin
            parent[ra] <= r;
            wsum <= wsum + SumBits'(ew);
            acc <= acc + 1'b1;
            state <= S_OUT;
          end else begin
            i <= i + 1'b1;
            state <= S_WRD;
          end
        end
        S_OUT: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata <= {7'b0, dropped, acc, wsum, 16'(ew), et, ef};
          m_tuser <= 1'b0;
          m_tlast <= 1'b0;
          i <= i + 1'b1;
          state <= S_WRD;
        end
        S_SUM: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata <= {7'b0, dropped, acc, wsum, 24'd0};
          m_tuser <= 1'b1;
          m_tlast <= 1'b1;
          loaded <= '0;
          dropped <= 1'b0;
          wsum <= '0;
          acc <= '0;
          state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

[sv/mstk_ram.sv]
// ----------------------------------------------------------------------------
// mstk_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mstk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[dv/mstk_checker.sv]
// ----------------------------------------------------------------------------
// mstk_checker
// Predicts and checks the spanning tree records of min_spanning_tree_kruskal.
// ----------------------------------------------------------------------------
// Watches configuration writes and input beats and keeps its own copy of the
// node count and the loaded edges. On each tlast beat it sorts the edges
// (stable by weight) and runs union-find to get the expected records. Each
// output beat is compared with the oldest expected record.
module mstk_checker
  import mstk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          pending,
  output int          trees_seen,
  output int          records_seen
);
  localparam int MaxNodes = 16;
  localparam int MaxEdges = 32;

  typedef struct packed {
    logic [3:0]  from_node;
    logic [3:0]  to_node;
    logic [15:0] weight;
  } edge_t;

  typedef struct packed {
    logic [3:0]  tree_from;
    logic [3:0]  tree_to;
    logic [15:0] tree_weight;
    logic [19:0] total_weight;
    logic [3:0]  tree_edges;
    logic        is_summary;
    logic        overflow;
    logic        last_result;
  } tree_rec_t;

  tree_rec_t   tree_q[$];
  edge_t       loaded[MaxEdges];
  int          loaded_cnt;
  logic        store_full_seen;
  logic [4:0]  nodes_used;
  logic [3:0]  uf_parent[MaxNodes];

  assign pending = tree_q.size();

  function automatic logic [3:0] find_root(logic [3:0] x);
    logic [3:0] r;
    logic [3:0] c;
    logic [3:0] nx;
    r = x;
    while (uf_parent[r] != r) r = uf_parent[r];
    c = x;
    while (c != r) begin
      nx = uf_parent[c];
      uf_parent[c] = r;
      c = nx;
    end
    return r;
  endfunction

  task automatic solve_tree();
    int         order[MaxEdges];
    int         j;
    int         cur;
    logic [3:0] ra;
    logic [3:0] rb;
    logic [19:0] sum;
    logic [3:0] cnt;
    tree_rec_t  rec;
    for (int i = 0; i < loaded_cnt; i++) begin
      cur = i;
      j = i;
      while (j > 0 && loaded[order[j-1]].weight > loaded[cur].weight) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int i = 0; i < MaxNodes; i++) uf_parent[i] = i[3:0];
    sum = '0;
    cnt = '0;
    for (int i = 0; i < loaded_cnt && int'(cnt) + 1 < int'(nodes_used); i++) begin
      ra = find_root(loaded[order[i]].from_node);
      rb = find_root(loaded[order[i]].to_node);
      if (ra != rb) begin
        uf_parent[ra] = rb;
        sum = sum + 20'(loaded[order[i]].weight);
        cnt = cnt + 4'd1;
        rec = '{loaded[order[i]].from_node, loaded[order[i]].to_node,
                loaded[order[i]].weight, sum, cnt, 1'b0, store_full_seen, 1'b0};
        tree_q.push_back(rec);
      end
    end
    rec = '{4'd0, 4'd0, 16'd0, sum, cnt, 1'b1, store_full_seen, 1'b1};
    tree_q.push_back(rec);
    loaded_cnt = 0;
    store_full_seen = 1'b0;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    trees_seen = 0;
    records_seen = 0;
    loaded_cnt = 0;
    store_full_seen = 1'b0;
    nodes_used = 5'd16;
  end

  always @(posedge clk) begin
    tree_rec_t want;
    edge_t     e;
    if (rst) begin
      loaded_cnt = 0;
      store_full_seen = 1'b0;
      nodes_used = 5'd16;
    end else begin
      if (cfg_we)
        nodes_used = (cfg_wdata < 2) ? 5'd2 : (cfg_wdata > MaxNodes) ? 5'd16 : cfg_wdata;
      if (s_tvalid && s_tready) begin
        e = '{s_tdata[3:0], s_tdata[7:4], s_tdata[23:8]};
        if (e.from_node < nodes_used && e.to_node < nodes_used) begin
          if (loaded_cnt < MaxEdges) loaded[loaded_cnt++] = e;
          else store_full_seen = 1'b1;
        end
        if (s_tlast) begin
          solve_tree();
          trees_seen++;
        end
      end
      if (m_tvalid && m_tready) begin
        records_seen++;
        if (tree_q.size() == 0) begin
          $display("MISMATCH unexpected record at %0t", $realtime);
          errors++;
        end else begin
          want = tree_q.pop_front();
          if (m_tdata[3:0] != want.tree_from) report("tree_from", m_tdata[3:0], want.tree_from);
          if (m_tdata[7:4] != want.tree_to) report("tree_to", m_tdata[7:4], want.tree_to);
          if (m_tdata[23:8] != want.tree_weight)
            report("tree_weight", m_tdata[23:8], want.tree_weight);
          if (m_tdata[43:24] != want.total_weight)
            report("total_weight", m_tdata[43:24], want.total_weight);
          if (m_tdata[47:44] != want.tree_edges)
            report("tree_edges", m_tdata[47:44], want.tree_edges);
          if (m_tuser != want.is_summary) report("is_summary", m_tuser, want.is_summary);
          if (m_tlast != want.last_result) report("last_result", m_tlast, want.last_result);
          if (m_tdata[48] != want.overflow) report("overflow", m_tdata[48], want.overflow);
        end
      end
    end
  end
endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for min_spanning_tree_kruskal.
// ----------------------------------------------------------------------------
// Drives directed graphs (empty, self loops, ties, extreme weights, nodes out
// of range, store overflow, clamped node counts) and then random graphs under
// random stalls on both sides; mstk_checker does the checking.
module testbench;
  import mstk_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  int          errors;
  int          pending;
  int          trees_seen;
  int          records_seen;
  int          edges_sent;
  int          nodes_now;
  logic        long_hold;
  logic        hold_done;

  min_spanning_tree_kruskal i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  mstk_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast), .errors(errors), .pending(pending),
    .trees_seen(trees_seen), .records_seen(records_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("min_spanning_tree_kruskal test failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sink side: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold && !hold_done) begin
        // long enough to outlast a full-store solve so the input stalls
        m_tready = 1'b0;
        repeat (4000) @(negedge clk);
        hold_done = 1'b1;
      end
      m_tready = 1'b1;
      repeat ($urandom_range(0, 99) < 30 ? $urandom_range(1, 30) : 1) @(negedge clk);
      if (pick_gap() > 0) begin
        m_tready = 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
      end
    end
  end

  task automatic send_edge(int from_node, int to_node, int weight, bit last_edge);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {weight[15:0], to_node[3:0], from_node[3:0]};
    s_tlast = last_edge;
    do @(posedge clk); while (!s_tready);
    edges_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    // an item with no result might still be busy in the block
    repeat (20) @(negedge clk);
  endtask

  task automatic set_nodes(int value);
    cfg_we = 1'b1;
    cfg_wdata = value[4:0];
    @(negedge clk);
    cfg_we = 1'b0;
    nodes_now = (value < 2) ? 2 : (value > 16) ? 16 : value;
  endtask

  function automatic int rand_node();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, nodes_now - 1);
  endfunction

  task automatic random_graph(int n_edges);
    for (int i = 0; i < n_edges; i++) begin
      int w;
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 65535);
      send_edge(rand_node(), rand_node(), w, i == n_edges - 1);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    long_hold = 1'b0;
    edges_sent = 0;
    nodes_now = 16;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: reset node count, empty graph and extremes
    send_edge(0, 0, 0, 1'b1);
    drain();
    send_edge(0, 15, 16'hFFFF, 1'b0);
    send_edge(15, 0, 16'hFFFF, 1'b0);
    send_edge(3, 3, 0, 1'b0);
    send_edge(5, 10, 100, 1'b0);
    send_edge(10, 15, 100, 1'b0);
    send_edge(5, 15, 100, 1'b1);
    drain();
    set_nodes(0);
    send_edge(0, 1, 7, 1'b0);
    send_edge(1, 0, 3, 1'b0);
    send_edge(2, 1, 1, 1'b1);
    drain();
    set_nodes(1);
    send_edge(7, 7, 9, 1'b1);
    drain();
    set_nodes(31);
    send_edge(15, 14, 42, 1'b1);
    drain();
    set_nodes(5);
    send_edge(4, 1, 20, 1'b0);
    send_edge(5, 1, 1, 1'b0);
    send_edge(0, 4, 20, 1'b0);
    send_edge(2, 3, 20, 1'b1);
    drain();
    // store overflow while the sink stalls for a long stretch; the next graph
    // is offered right away and waits behind the unread results
    set_nodes(16);
    long_hold = 1'b1;
    random_graph(36);
    random_graph(4);
    drain();

    while (edges_sent < 250) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        set_nodes($urandom_range(0, 31));
      end
      random_graph(($urandom_range(0, 9) == 0) ? $urandom_range(20, 36)
                                                : $urandom_range(1, 10));
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();
    set_nodes(2);
    random_graph(6);
    drain();

    repeat (100) @(negedge clk);
    $display("Ran %0d edge beats into %0d graphs, %0d tree records checked.",
             edges_sent, trees_seen, records_seen);
    if (errors == 0 && pending == 0) begin
      $display("min_spanning_tree_kruskal test passed");
    end else begin
      $display("min_spanning_tree_kruskal test failed");
    end
    $finish;
  end
endmodule
